/* hw/rtl/pqpe_pkg.sv */
// Package for the P/Q parity block encoder.
// Holds field widths, register indexes, controller/datapath bundles and GF(2^8) math.
// No dependencies.
package pqpe_pkg;

	localparam int SEQ_W      = 16;
	localparam int FLEN_W     = 11;
	localparam int BYTE_W     = 8;
	localparam int BS_W       = 8;
	localparam int OFF_W      = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int DIV_STEPS  = SEQ_W;
	localparam int EXP_STEPS  = BS_W;
	localparam int CNT_W      = 4;

	localparam logic [8:0]        GF_POLY    = 9'h11d;
	localparam logic [BS_W-1:0]   BS_RESET   = 8'd4;
	localparam logic [BYTE_W-1:0] GF_ONE     = 8'h01;
	localparam logic [BYTE_W-1:0] GF_TWO     = 8'h02;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE     = 1'b0,
		REG_BLOCK_SIZE = 1'b1
	} cfg_reg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic frame_set;
		logic exp_step;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic enable;
		logic first_byte;
		logic flen_zero;
		logic needs_out;
		logic out_free;
	} sts_t;

	// Carry-less multiply reduced by the 0x11d polynomial.
	function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] x,
		input logic [BYTE_W-1:0] y);
		logic [8:0]        a;
		logic [BYTE_W-1:0] r;
		a = {1'b0, x};
		r = '0;
		for (int k = 0; k < BYTE_W; k++) begin
			if (y[k]) begin
				r = r ^ a[BYTE_W-1:0];
			end
			a = {a[BYTE_W-1:0], 1'b0};
			if (a[8]) begin
				a = a ^ GF_POLY;
			end
		end
		return r;
	endfunction

endpackage

/* hw/rtl/pqpe_in_if.sv */
// Input stream interface of the P/Q parity block encoder: one frame byte per beat.
// Depends on pqpe_pkg.
interface pqpe_in_if;
	import pqpe_pkg::*;

	logic              valid;
	logic              ready;
	logic [SEQ_W-1:0]  seq;
	logic [FLEN_W-1:0] frame_len;
	logic [BYTE_W-1:0] data_byte;
	logic              frame_end;

	modport source (output valid, output seq, output frame_len, output data_byte,
		output frame_end, input ready);
	modport sink (input valid, input seq, input frame_len, input data_byte,
		input frame_end, output ready);
endinterface

/* hw/rtl/pqpe_out_if.sv */
// Output stream interface of the P/Q parity block encoder: one parity byte pair per beat.
// Depends on pqpe_pkg.
interface pqpe_out_if;
	import pqpe_pkg::*;

	logic              valid;
	logic              ready;
	logic [SEQ_W-1:0]  block_start;
	logic [BS_W-1:0]   frames_in_block;
	logic [OFF_W-1:0]  byte_offset;
	logic [BYTE_W-1:0] p_byte;
	logic [BYTE_W-1:0] q_byte;
	logic              parity_end;

	modport source (output valid, output block_start, output frames_in_block,
		output byte_offset, output p_byte, output q_byte, output parity_end, input ready);
	modport sink (input valid, input block_start, input frames_in_block,
		input byte_offset, input p_byte, input q_byte, input parity_end, output ready);
endinterface

/* hw/rtl/pq_parity_block_encoder_top.sv */
// P/Q parity block encoder, top level. A beat continuing a frame is accepted and then
// goes to the store update; a frame's first beat goes through the restoring slot
// division, opening or joining the block and the GF(2^8) 2^slot exponent, then the
// update. A result is registered and valid in the cycle after the update commits.
// Disabled and zero-length first beats are dropped on acceptance.
// Reset (arst_n low) clears control and config; the P/Q stores are not cleared.
module pq_parity_block_encoder_top #(
	parameter int MAX_FRAME_BYTES = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pqpe_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pqpe_pkg::CFG_DATA_W-1:0] cfg_data,
	pqpe_in_if.sink                         frame,
	pqpe_out_if.source                      parity
);
	import pqpe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pqpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frame.valid),
		.in_ready (frame.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pqpe_dp #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_data        (cfg_data),
		.seq             (frame.seq),
		.frame_len       (frame.frame_len),
		.data_byte       (frame.data_byte),
		.frame_end       (frame.frame_end),
		.cmd             (cmd),
		.sts             (sts),
		.out_ready       (parity.ready),
		.out_valid       (parity.valid),
		.block_start     (parity.block_start),
		.frames_in_block (parity.frames_in_block),
		.byte_offset     (parity.byte_offset),
		.p_byte          (parity.p_byte),
		.q_byte          (parity.q_byte),
		.parity_end      (parity.parity_end)
	);

	// a result only enters the output register when it has room
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && sts.needs_out) |-> sts.out_free)
		else $error("result committed into a full output register");

	// an enabled continuing beat keeps the input closed for its update cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.ready && sts.enable && !sts.first_byte) |=> !frame.ready)
		else $error("input reopened before store update");

	// a new result beat follows a store update
	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(parity.valid) |-> $past(cmd.commit))
		else $error("result appeared without a store update");
endmodule

/* hw/rtl/pqpe_ctrl.sv */
// Controller of the P/Q parity block encoder: sequences accept, slot division,
// coefficient exponentiation and the store update. Depends on pqpe_pkg.
module pqpe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pqpe_pkg::sts_t sts,
	output pqpe_pkg::cmd_t cmd
);
	import pqpe_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FRAME,
		ST_EXP,
		ST_UPDATE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             drop;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	// Disabled beats and zero-length first beats vanish without leaving ST_IDLE.
	assign drop     = !sts.enable || (sts.first_byte && sts.flen_zero);

	always_comb begin
		cmd           = '0;
		cmd.load      = accept;
		cmd.div_step  = (state_q == ST_DIV);
		cmd.frame_set = (state_q == ST_FRAME);
		cmd.exp_step  = (state_q == ST_EXP);
		cmd.commit    = (state_q == ST_UPDATE) && (!sts.needs_out || sts.out_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && !drop) begin
						state_q <= sts.first_byte ? ST_DIV : ST_UPDATE;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_FRAME;
					end
				end
				ST_FRAME: begin
					cnt_q   <= '0;
					state_q <= ST_EXP;
				end
				ST_EXP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(EXP_STEPS - 1)) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					// hold until the output register can take the result
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

/* hw/rtl/pqpe_dp.sv */
// Datapath of the P/Q parity block encoder: config registers, block state,
// slot divider, GF(2^8) exponent unit, P/Q stores and output register. Depends on pqpe_pkg.
module pqpe_dp #(
	parameter int MAX_FRAME_BYTES = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pqpe_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pqpe_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [pqpe_pkg::SEQ_W-1:0]      seq,
	input  logic [pqpe_pkg::FLEN_W-1:0]     frame_len,
	input  logic [pqpe_pkg::BYTE_W-1:0]     data_byte,
	input  logic                            frame_end,
	input  pqpe_pkg::cmd_t                  cmd,
	output pqpe_pkg::sts_t                  sts,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [pqpe_pkg::SEQ_W-1:0]      block_start,
	output logic [pqpe_pkg::BS_W-1:0]       frames_in_block,
	output logic [pqpe_pkg::OFF_W-1:0]      byte_offset,
	output logic [pqpe_pkg::BYTE_W-1:0]     p_byte,
	output logic [pqpe_pkg::BYTE_W-1:0]     q_byte,
	output logic                            parity_end
);
	import pqpe_pkg::*;

	localparam int AW = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
	localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int CW = (PW > FLEN_W) ? PW : FLEN_W;

	// control state
	logic              enable_q;
	logic [BS_W-1:0]   bs_q;
	logic [SEQ_W-1:0]  open_start_q;
	logic [FLEN_W-1:0] open_flen_q;
	logic [BS_W-1:0]   frames_done_q;
	logic [PW-1:0]     pos_q;
	logic              restart_q;
	logic              closing_q;
	logic [BYTE_W-1:0] coef_q;
	logic              out_valid_q;

	// payload state
	logic [SEQ_W-1:0]  seq_q;
	logic [FLEN_W-1:0] flen_q;
	logic [BYTE_W-1:0] data_q;
	logic              fend_q;
	logic [SEQ_W-1:0]  quo_q;
	logic [BS_W-1:0]   rem_q;
	logic [BS_W-1:0]   ex_q;
	logic [BYTE_W-1:0] base_q;
	logic [BYTE_W-1:0] p_rd_q;
	logic [BYTE_W-1:0] q_rd_q;
	logic [BYTE_W-1:0] p_mem [MAX_FRAME_BYTES];
	logic [BYTE_W-1:0] q_mem [MAX_FRAME_BYTES];
	logic [SEQ_W-1:0]  ob_start_q;
	logic [BS_W-1:0]   ob_size_q;
	logic [OFF_W-1:0]  ob_off_q;
	logic [BYTE_W-1:0] ob_p_q;
	logic [BYTE_W-1:0] ob_q_q;
	logic              ob_end_q;

	logic [BS_W:0]     div_trial;
	logic              div_fits;
	logic [SEQ_W-1:0]  start_new;
	logic              restart_new;
	logic [BS_W-1:0]   fd_eff;
	logic              closing_new;
	logic              in_range;
	logic [BYTE_W-1:0] q_term;
	logic [BYTE_W-1:0] p_new;
	logic [BYTE_W-1:0] q_new;
	logic              emit;
	logic [AW-1:0]     addr;

	assign addr = pos_q[AW-1:0];

	// one restoring step: shift in the next seq bit, subtract if it fits
	assign div_trial = {rem_q, quo_q[SEQ_W-1]};
	assign div_fits  = div_trial >= {1'b0, bs_q};

	assign start_new   = seq_q - SEQ_W'(rem_q);
	assign restart_new = (frames_done_q == '0) || (flen_q != open_flen_q) ||
		(start_new != open_start_q);
	assign fd_eff      = restart_new ? '0 : frames_done_q;
	assign closing_new = ({1'b0, fd_eff} + 9'd1) >= {1'b0, bs_q};

	assign in_range = (CW'(pos_q) < CW'(open_flen_q)) && (CW'(pos_q) < CW'(MAX_FRAME_BYTES));
	assign q_term   = gf_mul(data_q, coef_q);
	assign p_new    = restart_q ? data_q : (p_rd_q ^ data_q);
	assign q_new    = restart_q ? q_term : (q_rd_q ^ q_term);
	assign emit     = cmd.commit && closing_q && in_range;

	always_comb begin
		sts            = '0;
		sts.enable     = enable_q;
		sts.first_byte = (pos_q == '0);
		sts.flen_zero  = (frame_len == '0);
		sts.needs_out  = closing_q && in_range;
		sts.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			bs_q          <= BS_RESET;
			open_start_q  <= '0;
			open_flen_q   <= '0;
			frames_done_q <= '0;
			pos_q         <= '0;
			restart_q     <= 1'b0;
			closing_q     <= 1'b0;
			coef_q        <= GF_ONE;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_ENABLE: begin
						if (cfg_data[0] != enable_q) begin
							enable_q      <= cfg_data[0];
							frames_done_q <= '0;
							pos_q         <= '0;
							restart_q     <= 1'b0;
							closing_q     <= 1'b0;
							coef_q        <= GF_ONE;
						end
					end
					REG_BLOCK_SIZE: begin
						if (cfg_data != '0 && cfg_data != bs_q) begin
							bs_q          <= cfg_data;
							frames_done_q <= '0;
							pos_q         <= '0;
							restart_q     <= 1'b0;
							closing_q     <= 1'b0;
							coef_q        <= GF_ONE;
						end
					end
					default: begin
					end
				endcase
			end else if (cmd.frame_set) begin
				if (restart_new) begin
					open_start_q  <= start_new;
					open_flen_q   <= flen_q;
					frames_done_q <= '0;
				end
				restart_q <= restart_new;
				closing_q <= closing_new;
				coef_q    <= GF_ONE;
			end else if (cmd.exp_step) begin
				if (ex_q[0]) begin
					coef_q <= gf_mul(coef_q, base_q);
				end
			end else if (cmd.commit) begin
				if (fend_q) begin
					frames_done_q <= closing_q ? '0 : frames_done_q + 1'b1;
					pos_q         <= '0;
					restart_q     <= 1'b0;
					closing_q     <= 1'b0;
				end else if (pos_q != PW'(MAX_FRAME_BYTES)) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	// input capture, divider and exponent unit
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seq_q  <= seq;
			flen_q <= frame_len;
			data_q <= data_byte;
			fend_q <= frame_end;
			quo_q  <= seq;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SEQ_W-2:0], 1'b0};
			rem_q <= div_fits ? BS_W'(div_trial - {1'b0, bs_q}) : div_trial[BS_W-1:0];
		end
		if (cmd.frame_set) begin
			ex_q   <= rem_q;
			base_q <= GF_TWO;
		end else if (cmd.exp_step) begin
			ex_q   <= {1'b0, ex_q[BS_W-1:1]};
			base_q <= gf_mul(base_q, base_q);
		end
	end

	// P/Q stores: read the current position every cycle, write on an in-range commit
	always_ff @(posedge clk) begin
		p_rd_q <= p_mem[addr];
		q_rd_q <= q_mem[addr];
		if (cmd.commit && in_range) begin
			p_mem[addr] <= p_new;
			q_mem[addr] <= q_new;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ob_start_q <= open_start_q;
			ob_size_q  <= bs_q;
			ob_off_q   <= OFF_W'(pos_q);
			ob_p_q     <= p_new;
			ob_q_q     <= q_new;
			ob_end_q   <= fend_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign block_start     = ob_start_q;
	assign frames_in_block = ob_size_q;
	assign byte_offset     = ob_off_q;
	assign p_byte          = ob_p_q;
	assign q_byte          = ob_q_q;
	assign parity_end      = ob_end_q;
endmodule
